[sv/frer_pkg.sv]
`timescale 1ns / 1ps
package frer_pkg;

    localparam int COORD_W           = 48;
    localparam int ANG_W             = 32;
    localparam int TRIG_W            = 34;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int RED_STEPS         = 24;
    localparam int RED_W             = 65;
    localparam int QUEUE_DEPTH       = 4;
    localparam int FOLD_W            = 35;

    localparam logic [RED_W-1:0] TWO_PI_Q38 = 65'h1921FB54443;
    // A multiple of 2*pi that lifts any signed 64-bit angle to a nonnegative value.
    localparam logic [RED_W-1:0] RED_OFFSET = TWO_PI_Q38 << RED_STEPS - 1;

    localparam logic signed [FOLD_W-1:0] TWO_PI_Q30  = 35'sh1921FB544;
    localparam logic signed [FOLD_W-1:0] PI_Q30      = 35'sh0C90FDAA2;
    localparam logic signed [FOLD_W-1:0] HALF_PI_Q30 = 35'sh06487ED51;
    localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 34'sh026DD3B6A;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_coords;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c2;
        logic signed [TRIG_W-1:0] s2;
        t_coords                  pos;
    } t_work;

    // Returns 2*pi scaled by 2^k; reduction step k removes the value for RED_STEPS-k when it fits.
    function automatic logic [RED_W-1:0] red_sub(input int k);
        return TWO_PI_Q38 << k;
    endfunction

    // Arctangent of 2^-i in Q.30, rounded down.
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] head [0:10];
        head[0]  = 32'h3243F6A8;
        head[1]  = 32'h1DAC6705;
        head[2]  = 32'h0FADBAFC;
        head[3]  = 32'h07F56EA6;
        head[4]  = 32'h03FEAB76;
        head[5]  = 32'h01FFD55B;
        head[6]  = 32'h00FFFAAA;
        head[7]  = 32'h007FFF55;
        head[8]  = 32'h003FFFEA;
        head[9]  = 32'h001FFFFD;
        head[10] = 32'h000FFFFF;
        if (i <= 10) begin
            return head[i];
        end else if (i <= 30) begin
            return (32'd1 << (30 - i)) - 32'd1;
        end
        return 32'd0;
    endfunction

endpackage

[sv/frer_ifs.sv]
`timescale 1ns / 1ps
interface frer_in_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] ecef_x;
    logic signed [47:0] ecef_y;
    logic signed [47:0] ecef_z;
    logic signed [31:0] theta_angle;
    logic signed [31:0] rotation_rate;
    logic        [31:0] elapsed_time;

    modport source (output valid, ecef_x, ecef_y, ecef_z, theta_angle, rotation_rate,
                    elapsed_time, input ready);
    modport sink   (input valid, ecef_x, ecef_y, ecef_z, theta_angle, rotation_rate,
                    elapsed_time, output ready);
endinterface

interface frer_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] eci_x;
    logic signed [47:0] eci_y;
    logic signed [47:0] eci_z;
    logic               saturated;

    modport source (output valid, eci_x, eci_y, eci_z, saturated, input ready);
    modport sink   (input valid, eci_x, eci_y, eci_z, saturated, output ready);
endinterface

[sv/frame_rotation_ecef_to_eci_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Payload                                              Handshake
// i_in      sink       ecef_x/y/z, theta_angle, rotation_rate, elapsed_time valid/ready
// o_out     source     eci_x/y/z, saturated                                 valid/ready
//
// One transaction is accepted per cycle while the front is not held. A transaction passes
// through the front (angle product, 2*pi reduction steps, quadrant fold, CORDIC stages),
// is registered in the four-entry queue and then passes through the back (two split
// multiplies of three stages each and the saturating output register) to the output.
// Reset is synchronous and active low; it clears only valid bits and queue pointers.
// A stalled output holds the back; the front keeps running until the queue is full.
module frame_rotation_ecef_to_eci_unit
    import frer_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frer_in_if.sink     i_in,
    frer_out_if.source  o_out
);

    // The front computes both sine/cosine pairs and forwards them with the position.
    logic  push, pop, full, empty;
    t_work front_work, queue_work;

    frer_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_push_ok (!full || pop),
        .o_push    (push),
        .o_work    (front_work)
    );

    // The short queue lets the back stall on the output without freezing the front.
    frer_fifo #(.WIDTH($bits(t_work)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (queue_work)
    );

    // The back applies the two rotations and saturates the final coordinates.
    frer_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!empty),
        .i_work  (queue_work),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[sv/frer_front.sv]
`timescale 1ns / 1ps
module frer_front
    import frer_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frer_in_if.sink     i_in,
    input  logic        i_push_ok,
    output logic        o_push,
    output t_work       o_work
);

    localparam int TOT = 4 + RED_STEPS + CORDIC_STAGES;

    logic                     fen;
    logic                     r_pv   [0:TOT-1];
    t_coords                  r_crd  [0:TOT-2];
    logic signed [63:0]       r_ang  [0:1];
    logic [RED_W-1:0]         r_red  [0:RED_STEPS][0:1];
    logic signed [TRIG_W-1:0] r_cx   [0:CORDIC_STAGES][0:1];
    logic signed [TRIG_W-1:0] r_cy   [0:CORDIC_STAGES][0:1];
    logic signed [TRIG_W-1:0] r_cz   [0:CORDIC_STAGES][0:1];
    logic                     r_neg  [0:CORDIC_STAGES][0:1];
    t_work                    r_work;
    logic signed [64:0]       n_prod;

    // The whole front moves together; it holds only when its last stage cannot leave.
    assign fen        = !r_pv[TOT-1] || i_push_ok;
    assign i_in.ready = fen;
    assign o_push     = r_pv[TOT-1] && fen;
    assign o_work     = r_work;
    assign n_prod     = $signed({i_in.rotation_rate[31], i_in.rotation_rate})
                      * $signed({1'b0, i_in.elapsed_time});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TOT; j++) begin
                r_pv[j] <= 1'b0;
            end
        end else if (fen) begin
            r_pv[0] <= i_in.valid;
            for (int j = 1; j < TOT; j++) begin
                r_pv[j] <= r_pv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_crd[0].x <= i_in.ecef_x;
            r_crd[0].y <= i_in.ecef_y;
            r_crd[0].z <= i_in.ecef_z;
            for (int j = 1; j < TOT - 1; j++) begin
                r_crd[j] <= r_crd[j-1];
            end
            r_ang[0] <= {{22{i_in.theta_angle[31]}}, i_in.theta_angle, 10'b0};
            r_ang[1] <= n_prod[63:0];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [FOLD_W-1:0] n_fz;
        logic                     n_fneg;

        always_ff @(posedge i_clk) begin
            if (fen) begin
                r_red[0][l] <= {r_ang[l][63], r_ang[l]} + RED_OFFSET;
            end
        end

        for (genvar k = 1; k <= RED_STEPS; k++) begin : g_red
            localparam logic [RED_W-1:0] SUB = red_sub(RED_STEPS - k);
            always_ff @(posedge i_clk) begin
                if (fen) begin
                    r_red[k][l] <= (r_red[k-1][l] >= SUB) ? r_red[k-1][l] - SUB
                                                          : r_red[k-1][l];
                end
            end
        end

        // Bring the angle into [-pi/2, pi/2]; a half turn flips sine and cosine.
        always_comb begin
            n_fz   = $signed({2'b00, r_red[RED_STEPS][l][40:8]});
            n_fneg = 1'b0;
            if (n_fz > PI_Q30) begin
                n_fz = n_fz - TWO_PI_Q30;
            end
            if (n_fz > HALF_PI_Q30) begin
                n_fz   = n_fz - PI_Q30;
                n_fneg = 1'b1;
            end else if (n_fz < -HALF_PI_Q30) begin
                n_fz   = n_fz + PI_Q30;
                n_fneg = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (fen) begin
                r_cx[0][l]  <= INV_GAIN_Q30;
                r_cy[0][l]  <= '0;
                r_cz[0][l]  <= n_fz[TRIG_W-1:0];
                r_neg[0][l] <= n_fneg;
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
            localparam logic signed [TRIG_W-1:0] ATN = $signed({2'b00, atan_q30(i)});
            logic signed [TRIG_W-1:0] dx;
            logic signed [TRIG_W-1:0] dy;
            assign dx = r_cy[i][l] >>> i;
            assign dy = r_cx[i][l] >>> i;
            always_ff @(posedge i_clk) begin
                if (fen) begin
                    r_neg[i+1][l] <= r_neg[i][l];
                    if (!r_cz[i][l][TRIG_W-1]) begin
                        r_cx[i+1][l] <= r_cx[i][l] - dx;
                        r_cy[i+1][l] <= r_cy[i][l] + dy;
                        r_cz[i+1][l] <= r_cz[i][l] - ATN;
                    end else begin
                        r_cx[i+1][l] <= r_cx[i][l] + dx;
                        r_cy[i+1][l] <= r_cy[i][l] - dy;
                        r_cz[i+1][l] <= r_cz[i][l] + ATN;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_work.pos <= r_crd[TOT-2];
            r_work.c1  <= r_neg[CORDIC_STAGES][0] ? -r_cx[CORDIC_STAGES][0]
                                                  : r_cx[CORDIC_STAGES][0];
            r_work.s1  <= r_neg[CORDIC_STAGES][0] ? -r_cy[CORDIC_STAGES][0]
                                                  : r_cy[CORDIC_STAGES][0];
            r_work.c2  <= r_neg[CORDIC_STAGES][1] ? -r_cx[CORDIC_STAGES][1]
                                                  : r_cx[CORDIC_STAGES][1];
            r_work.s2  <= r_neg[CORDIC_STAGES][1] ? -r_cy[CORDIC_STAGES][1]
                                                  : r_cy[CORDIC_STAGES][1];
        end
    end

endmodule

[sv/frer_fifo.sv]
`timescale 1ns / 1ps
module frer_fifo
    import frer_pkg::*;
#(
    parameter int WIDTH = $bits(t_work),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[sv/frer_mix.sv]
`timescale 1ns / 1ps
module frer_mix
    import frer_pkg::*;
#(
    parameter int AW = COORD_W,
    parameter int RW = COORD_W + 2
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [TRIG_W-1:0] i_p,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [TRIG_W-1:0] i_q,
    input  logic signed [AW-1:0]     i_b,
    output logic signed [RW-1:0]     o_res
);

    // (p*a + q*b + 2^29) >> 30, with a and b each split at bit 24.
    localparam int HPW = TRIG_W + AW - 24;
    localparam int LPW = TRIG_W + 25;
    localparam int HW  = HPW + 1;
    localparam int LW  = LPW + 2;
    localparam int SW  = HW + 1;

    logic signed [AW-25:0]  a_hi, b_hi;
    logic signed [24:0]     a_lo, b_lo;
    logic signed [HPW-1:0]  r_ph, r_qh;
    logic signed [LPW-1:0]  r_pl, r_ql;
    logic signed [HW-1:0]   r_hi;
    logic signed [LW-1:0]   r_lo;
    logic signed [LW-25:0]  lo_sh;
    logic signed [SW-1:0]   n_sum;
    logic signed [RW-1:0]   r_res;

    assign a_hi  = i_a[AW-1:24];
    assign b_hi  = i_b[AW-1:24];
    assign a_lo  = $signed({1'b0, i_a[23:0]});
    assign b_lo  = $signed({1'b0, i_b[23:0]});
    assign lo_sh = r_lo[LW-1:24];
    assign n_sum = SW'(r_hi) + SW'(lo_sh);
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph  <= i_p * a_hi;
            r_qh  <= i_q * b_hi;
            r_pl  <= i_p * a_lo;
            r_ql  <= i_q * b_lo;
            r_hi  <= HW'(r_ph) + HW'(r_qh);
            r_lo  <= LW'(r_pl) + LW'(r_ql) + (LW'(1) <<< 29);
            r_res <= n_sum[RW+5:6];
        end
    end

endmodule

[sv/frer_back.sv]
`timescale 1ns / 1ps
module frer_back
    import frer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_work       i_work,
    output logic        o_pop,
    frer_out_if.source  o_out
);

    localparam int X1W = COORD_W + 2;
    localparam int X2W = COORD_W + 3;

    logic                      ben;
    logic                      r_bv [0:5];
    logic                      r_ov;
    logic signed [TRIG_W-1:0]  r_c2 [0:2];
    logic signed [TRIG_W-1:0]  r_s2 [0:2];
    logic signed [COORD_W-1:0] r_z  [0:2];
    logic signed [X1W-1:0]     r_y1 [0:2];
    logic signed [X1W-1:0]     x1, y1;
    logic signed [X2W-1:0]     x2, z2;
    logic signed [COORD_W-1:0] r_ex, r_ey, r_ez;
    logic                      r_sat;
    logic                      ox, oy, oz;

    assign ben   = !r_ov || o_out.ready;
    assign o_pop = ben && i_valid;

    frer_mix #(.AW(COORD_W), .RW(X1W)) u_mix_x1 (
        .i_clk(i_clk), .i_en(ben),
        .i_p(i_work.c1), .i_a(i_work.pos.x), .i_q(i_work.s1), .i_b(i_work.pos.y),
        .o_res(x1)
    );
    frer_mix #(.AW(COORD_W), .RW(X1W)) u_mix_y1 (
        .i_clk(i_clk), .i_en(ben),
        .i_p(-i_work.s1), .i_a(i_work.pos.x), .i_q(i_work.c1), .i_b(i_work.pos.y),
        .o_res(y1)
    );
    frer_mix #(.AW(X1W), .RW(X2W)) u_mix_x2 (
        .i_clk(i_clk), .i_en(ben),
        .i_p(r_c2[2]), .i_a(x1), .i_q(r_s2[2]), .i_b(X1W'(r_z[2])),
        .o_res(x2)
    );
    frer_mix #(.AW(X1W), .RW(X2W)) u_mix_z2 (
        .i_clk(i_clk), .i_en(ben),
        .i_p(-r_s2[2]), .i_a(x1), .i_q(r_c2[2]), .i_b(X1W'(r_z[2])),
        .o_res(z2)
    );

    // A coordinate overflows when the field's top bit and the bits above it do not all match the sign.
    assign ox = (x2[X2W-1:COORD_W-1] != {(X2W-COORD_W+1){x2[X2W-1]}});
    assign oy = (r_y1[2][X1W-1:COORD_W-1] != {(X1W-COORD_W+1){r_y1[2][X1W-1]}});
    assign oz = (z2[X2W-1:COORD_W-1] != {(X2W-COORD_W+1){z2[X2W-1]}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 6; j++) begin
                r_bv[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (ben) begin
            r_bv[0] <= i_valid;
            for (int j = 1; j < 6; j++) begin
                r_bv[j] <= r_bv[j-1];
            end
            r_ov <= r_bv[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_c2[0] <= i_work.c2;
            r_s2[0] <= i_work.s2;
            r_z[0]  <= i_work.pos.z;
            r_y1[0] <= y1;
            for (int j = 1; j < 3; j++) begin
                r_c2[j] <= r_c2[j-1];
                r_s2[j] <= r_s2[j-1];
                r_z[j]  <= r_z[j-1];
                r_y1[j] <= r_y1[j-1];
            end
            r_ex  <= ox ? (x2[X2W-1] ? COORD_MIN : COORD_MAX) : x2[COORD_W-1:0];
            r_ey  <= oy ? (r_y1[2][X1W-1] ? COORD_MIN : COORD_MAX) : r_y1[2][COORD_W-1:0];
            r_ez  <= oz ? (z2[X2W-1] ? COORD_MIN : COORD_MAX) : z2[COORD_W-1:0];
            r_sat <= ox || oy || oz;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.eci_x     = r_ex;
    assign o_out.eci_y     = r_ey;
    assign o_out.eci_z     = r_ez;
    assign o_out.saturated = r_sat;

endmodule
